// ===== design/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// Types and constants shared by the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

   localparam int CODE_W   = 32;
   localparam int LEN_W    = 6;
   localparam int BYTE_W   = 8;
   localparam int PEND_W   = 7;
   localparam int STREAM_W = PEND_W + CODE_W + 1;
   localparam int TOTAL_W  = 32;

   typedef enum logic [1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_ENCODE = 2'd1,
      FUNC_FLUSH  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_CODED  = 2'd0,
      ST_FINAL  = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_REJECT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_EMIT,
      S_ONE
   } state_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } entry_type;

endpackage

// ===== design/hcbp_if.sv =====
// ----------------------------------------------------------------------------
// hcbp_if
// Valid/ready channels for request and response items.
// ----------------------------------------------------------------------------
interface hcbp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  symbol;
   logic [31:0] code_bits;
   logic [7:0]  code_len;

   modport source (output valid, func, symbol, code_bits, code_len, input ready);
   modport sink   (input valid, func, symbol, code_bits, code_len, output ready);
endinterface

interface hcbp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  out_byte;
   logic [31:0] total_bits;
   logic        last;

   modport source (output valid, status, out_byte, total_bits, last, input ready);
   modport sink   (input valid, status, out_byte, total_bits, last, output ready);
endinterface

// ===== design/hcbp_table.sv =====
// ----------------------------------------------------------------------------
// hcbp_table
// Code table memory, one entry per symbol, with per-entry valid bits.
// ----------------------------------------------------------------------------
module hcbp_table import hcbp_pkg::*; #(
   parameter int SYMBOLS = 256,
   parameter int AW      = $clog2(SYMBOLS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type          mem [SYMBOLS];
   logic [SYMBOLS-1:0] valid_ff;
   entry_type          rd_data_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // never-written entries read as length zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== design/hcbp_packer.sv =====
// ----------------------------------------------------------------------------
// hcbp_packer
// Sequencer: table access, bit packing, byte emission and result register.
// ----------------------------------------------------------------------------
module hcbp_packer import hcbp_pkg::*; #(
   parameter int SYMBOLS      = 256,
   parameter int MAX_CODE_LEN = 32,
   parameter int AW           = $clog2(SYMBOLS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [BYTE_W-1:0]  req_symbol,
   input  logic [CODE_W-1:0]  req_code_bits,
   input  logic [7:0]         req_code_len,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic [TOTAL_W-1:0] rsp_total_bits,
   output logic               rsp_last,
   output logic               tbl_wr_en,
   output logic [AW-1:0]      tbl_wr_addr,
   output entry_type          tbl_wr_data,
   output logic               tbl_rd_en,
   output logic [AW-1:0]      tbl_rd_addr,
   input  entry_type          tbl_rd_data
);

   localparam int LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

   state_type            state_ff, state_in;
   logic [PEND_W-1:0]    pend_ff, pend_in;
   logic [2:0]           pcnt_ff, pcnt_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [STREAM_W-1:0]  stream_ff, stream_in;
   logic [2:0]           nbytes_ff, nbytes_in;
   logic                 sym_ok_ff, sym_ok_in;
   status_type           one_status_ff, one_status_in;
   logic [BYTE_W-1:0]    one_byte_ff, one_byte_in;
   logic [TOTAL_W-1:0]   one_total_ff, one_total_in;
   logic                 ov_ff, ov_in;
   status_type           ost_ff, ost_in;
   logic [BYTE_W-1:0]    obyte_ff, obyte_in;
   logic [TOTAL_W-1:0]   ototal_ff, ototal_in;
   logic                 olast_ff, olast_in;

   logic                 in_range;
   logic                 slot_free;
   logic [LEN_W-1:0]     len;
   logic [LEN_W-1:0]     nsum;
   logic [CODE_W-1:0]    code_al;
   logic [STREAM_W-1:0]  stream;
   logic [TOTAL_W:0]     sum;

   assign in_range    = {1'b0, req_symbol} < (BYTE_W + 1)'(SYMBOLS);
   assign slot_free   = !ov_ff || rsp_ready;
   assign req_ready   = (state_ff == S_IDLE);
   assign tbl_wr_addr = req_symbol[AW-1:0];
   assign tbl_rd_addr = req_symbol[AW-1:0];
   assign tbl_wr_data = '{code: req_code_bits, len: req_code_len[LEN_W-1:0]};

   // left-aligned merge of pending bits and the looked-up code
   assign len     = sym_ok_ff ? tbl_rd_data.len : '0;
   assign nsum    = {3'b000, pcnt_ff} + len;
   assign code_al = tbl_rd_data.code << (LEN_W'(CODE_W) - len);
   assign stream  = {pend_ff, {(CODE_W + 1){1'b0}}} | ({code_al, 8'h00} >> pcnt_ff);
   assign sum     = {1'b0, total_ff} + (TOTAL_W + 1)'(len);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pend_ff   <= '0;
         pcnt_ff   <= '0;
         total_ff  <= '0;
         nbytes_ff <= '0;
         sym_ok_ff <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         pcnt_ff   <= pcnt_in;
         total_ff  <= total_in;
         nbytes_ff <= nbytes_in;
         sym_ok_ff <= sym_ok_in;
         ov_ff     <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      stream_ff     <= stream_in;
      one_status_ff <= one_status_in;
      one_byte_ff   <= one_byte_in;
      one_total_ff  <= one_total_in;
      ost_ff        <= ost_in;
      obyte_ff      <= obyte_in;
      ototal_ff     <= ototal_in;
      olast_ff      <= olast_in;
   end

   always_comb begin
      state_in      = state_ff;
      pend_in       = pend_ff;
      pcnt_in       = pcnt_ff;
      total_in      = total_ff;
      stream_in     = stream_ff;
      nbytes_in     = nbytes_ff;
      sym_ok_in     = sym_ok_ff;
      one_status_in = one_status_ff;
      one_byte_in   = one_byte_ff;
      one_total_in  = one_total_ff;
      ov_in         = ov_ff && !rsp_ready;
      ost_in        = ost_ff;
      obyte_in      = obyte_ff;
      ototal_in     = ototal_ff;
      olast_in      = olast_ff;
      tbl_wr_en     = 1'b0;
      tbl_rd_en     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_func)
                  FUNC_LOAD: begin
                     if (req_code_len > 8'(LIMIT) || !in_range) begin
                        one_status_in = ST_REJECT;
                        one_byte_in   = '0;
                        one_total_in  = '0;
                        state_in      = S_ONE;
                     end else begin
                        tbl_wr_en = 1'b1;
                     end
                  end
                  FUNC_ENCODE: begin
                     tbl_rd_en = in_range;
                     sym_ok_in = in_range;
                     state_in  = S_LOOK;
                  end
                  FUNC_FLUSH: begin
                     one_status_in = (pcnt_ff != '0) ? ST_FINAL : ST_EMPTY;
                     one_byte_in   = (pcnt_ff != '0) ? {pend_ff, 1'b0} : '0;
                     one_total_in  = total_ff;
                     pend_in       = '0;
                     pcnt_in       = '0;
                     total_in      = '0;
                     state_in      = S_ONE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LOOK: begin
            total_in  = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            pcnt_in   = nsum[2:0];
            nbytes_in = nsum[5:3];
            stream_in = stream;
            if (nsum[5:3] == '0) begin
               pend_in  = stream[STREAM_W-1 -: PEND_W];
               state_in = S_IDLE;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               ov_in     = 1'b1;
               ost_in    = ST_CODED;
               obyte_in  = stream_ff[STREAM_W-1 -: BYTE_W];
               ototal_in = '0;
               olast_in  = (nbytes_ff == 3'd1);
               stream_in = stream_ff << BYTE_W;
               nbytes_in = nbytes_ff - 3'd1;
               if (nbytes_ff == 3'd1) begin
                  pend_in  = stream_ff[STREAM_W-BYTE_W-1 -: PEND_W];
                  state_in = S_IDLE;
               end
            end
         end
         S_ONE: begin
            if (slot_free) begin
               ov_in     = 1'b1;
               ost_in    = one_status_ff;
               obyte_in  = one_byte_ff;
               ototal_in = one_total_ff;
               olast_in  = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid      = ov_ff;
   assign rsp_status     = ost_ff;
   assign rsp_out_byte   = obyte_ff;
   assign rsp_total_bits = ototal_ff;
   assign rsp_last       = olast_ff;

endmodule

// ===== design/huffman_code_bit_packer.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Huffman encoder back end: code table, MSB-first bit packer and flush.
//
//   channel  dir  payload                                  done when
//   req_if   in   func, symbol, code_bits, code_len        valid & ready
//   rsp_if   out  status, out_byte, total_bits, last       valid & ready
//
// Load writes the table on acceptance; a rejected load and a flush each give one
// result item. Encode reads the table (a registered read), merges the code with
// the pending bits, then emits one completed byte per cycle unless rsp_if stalls.
// Reset clears the table's valid bits at once; there is no clearing pass.
// A stalled rsp_if holds the output register; req_if.ready drops while busy.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer import hcbp_pkg::*; #(
   parameter int SYMBOLS      = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input logic        clock,
   input logic        reset,
   hcbp_req_if.sink   req_if,
   hcbp_rsp_if.source rsp_if
);

   localparam int AW = $clog2(SYMBOLS);

   logic          tbl_wr_en;
   logic [AW-1:0] tbl_wr_addr;
   entry_type     tbl_wr_data;
   logic          tbl_rd_en;
   logic [AW-1:0] tbl_rd_addr;
   entry_type     tbl_rd_data;

   hcbp_table #(
      .SYMBOLS (SYMBOLS),
      .AW      (AW)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   hcbp_packer #(
      .SYMBOLS      (SYMBOLS),
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .AW           (AW)
   ) u_packer (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_func       (req_if.func),
      .req_symbol     (req_if.symbol),
      .req_code_bits  (req_if.code_bits),
      .req_code_len   (req_if.code_len),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_status     (rsp_if.status),
      .rsp_out_byte   (rsp_if.out_byte),
      .rsp_total_bits (rsp_if.total_bits),
      .rsp_last       (rsp_if.last),
      .tbl_wr_en      (tbl_wr_en),
      .tbl_wr_addr    (tbl_wr_addr),
      .tbl_wr_data    (tbl_wr_data),
      .tbl_rd_en      (tbl_rd_en),
      .tbl_rd_addr    (tbl_rd_addr),
      .tbl_rd_data    (tbl_rd_data)
   );

endmodule

// ===== design/hcbp_checker.sv =====
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks on response items, bound to the top level.
// ----------------------------------------------------------------------------
module hcbp_checker import hcbp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_out_byte,
   input logic [31:0] rsp_total_bits,
   input logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_byte) && $stable(rsp_total_bits) && $stable(rsp_last))
      else $error("response item changed while stalled");

   a_total_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_CODED || rsp_status == ST_REJECT)
         |-> rsp_total_bits == '0)
      else $error("bit count on a non-flush item");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FINAL || rsp_status == ST_EMPTY
         || rsp_status == ST_REJECT) |-> rsp_last)
      else $error("single-result item without last");

   a_pad_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_REJECT
         || (rsp_status == ST_FINAL && rsp_out_byte[0])) |-> rsp_out_byte == '0)
      else $error("bad byte on a padded, empty or rejected item");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_status     (rsp_if.status),
   .rsp_out_byte   (rsp_if.out_byte),
   .rsp_total_bits (rsp_if.total_bits),
   .rsp_last       (rsp_if.last)
);

// ===== bench/huffman_code_bit_packer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_tb
// Self-checking bench for the Huffman code bit packer. Code table loads,
// symbol encodes and flushes are driven on the request channel. Each
// accepted item feeds a model of the table and the MSB-first byte packer,
// and every response item is checked in order against that model. Both
// channels idle in random bursts, and the run ends with a stretch of full
// throughput.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_tb import hcbp_pkg::*;;

   localparam int          MAX_LEN     = 32;
   localparam int          CYCLE_LIMIT = 200000;
   localparam logic [1:0]  FUNC_SPARE  = 2'd3;

   typedef struct {
      status_type  status;
      logic [7:0]  out_byte;
      logic [31:0] total_bits;
      logic        last;
   } byte_result_type;

   class packer_scoreboard;
      logic [31:0]     code_word [256];
      logic [7:0]      code_size [256];
      logic [7:0]      shift_reg;
      int unsigned     shift_count;
      logic [31:0]     bit_count;
      byte_result_type owed[$];
      int unsigned     errors, results_seen;
      int unsigned     loads, rejects, encodes, flushes, spares;

      function new();
         foreach (code_word[i]) begin
            code_word[i] = '0;
            code_size[i] = '0;
         end
         shift_reg   = '0;
         shift_count = 0;
         bit_count   = '0;
      endfunction

      function void owe(status_type st, logic [7:0] ob, logic [31:0] tot, logic lst);
         byte_result_type r;
         r.status     = st;
         r.out_byte   = ob;
         r.total_bits = tot;
         r.last       = lst;
         owed.push_back(r);
      endfunction

      function void note_request(logic [1:0] f, logic [7:0] sym, logic [31:0] bits,
                                 logic [7:0] len);
         int unsigned clen;
         int          n;
         logic [7:0]  padded;
         case (f)
            FUNC_LOAD: begin
               loads++;
               if (len > MAX_LEN) begin
                  rejects++;
                  owe(ST_REJECT, 8'h00, 32'd0, 1'b1);
               end else begin
                  code_size[sym] = len;
                  code_word[sym] = (len == 32) ? bits : bits & ((32'd1 << len) - 32'd1);
               end
            end
            FUNC_ENCODE: begin
               encodes++;
               clen = code_size[sym];
               n = 0;
               for (int i = int'(clen) - 1; i >= 0; i--) begin
                  shift_reg = {shift_reg[6:0], code_word[sym][i]};
                  shift_count++;
                  if (shift_count == 8) begin
                     owe(ST_CODED, shift_reg, 32'd0, 1'b0);
                     n++;
                     shift_reg   = '0;
                     shift_count = 0;
                  end
               end
               if (n > 0)
                  owed[owed.size()-1].last = 1'b1;
               if (bit_count > 32'hFFFF_FFFF - clen)
                  bit_count = 32'hFFFF_FFFF;
               else
                  bit_count += clen;
            end
            FUNC_FLUSH: begin
               flushes++;
               if (shift_count > 0) begin
                  padded = shift_reg << (8 - shift_count);
                  owe(ST_FINAL, padded, bit_count, 1'b1);
               end else begin
                  owe(ST_EMPTY, 8'h00, bit_count, 1'b1);
               end
               shift_reg   = '0;
               shift_count = 0;
               bit_count   = '0;
            end
            default: spares++;
         endcase
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
      endfunction

      function void check_response(logic [1:0] st, logic [7:0] ob, logic [31:0] tot,
                                   logic lst);
         byte_result_type want;
         results_seen++;
         if (owed.size() == 0) begin
            note_error($sformatf("unexpected item status %0d byte %02h total %0d last %0b",
                                 st, ob, tot, lst));
            return;
         end
         want = owed.pop_front();
         if (st !== want.status || ob !== want.out_byte || tot !== want.total_bits ||
             lst !== want.last)
            note_error($sformatf({"status %0d/%0d byte %02h/%02h total %0d/%0d ",
                                  "last %0b/%0b (expected/actual)"},
                                 want.status, st, want.out_byte, ob, want.total_bits, tot,
                                 want.last, lst));
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   idle_on = 1'b1;
   int unsigned cycle_count = 0;
   logic [7:0] hot [16];

   packer_scoreboard sb = new();

   hcbp_req_if req_ch ();
   hcbp_rsp_if rsp_ch ();

   huffman_code_bit_packer #(
      .SYMBOLS      (256),
      .MAX_CODE_LEN (MAX_LEN)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items still owed", cycle_count,
                  sb.owed.size());
         $display("huffman_code_bit_packer_tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.func, req_ch.symbol, req_ch.code_bits, req_ch.code_len);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.status, rsp_ch.out_byte, rsp_ch.total_bits,
                              rsp_ch.last);
      end
   end

   // response side: random stall bursts while idling is on
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   task automatic send_item(input logic [1:0] f, input logic [7:0] sym,
                            input logic [31:0] bits, input logic [7:0] len);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= f;
      req_ch.symbol    <= sym;
      req_ch.code_bits <= bits;
      req_ch.code_len  <= len;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
   endtask

   task automatic random_item();
      int unsigned pick, len_kind;
      logic [7:0]  sym;
      logic [7:0]  len;
      pick     = $urandom_range(0, 99);
      sym      = ($urandom_range(0, 4) != 0) ? hot[$urandom_range(0, 15)]
                                               : 8'($urandom_range(0, 255));
      len_kind = $urandom_range(0, 19);
      if (len_kind == 0)
         len = 8'd0;
      else if (len_kind == 1)
         len = 8'($urandom_range(MAX_LEN + 1, 255));
      else if (len_kind < 5)
         len = 8'($urandom_range(25, MAX_LEN));
      else
         len = 8'($urandom_range(1, 12));
      if (pick < 12)
         send_item(FUNC_LOAD, sym, $urandom, len);
      else if (pick < 85)
         send_item(FUNC_ENCODE, sym, $urandom, 8'($urandom_range(0, 255)));
      else if (pick < 96)
         send_item(FUNC_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                   8'($urandom_range(0, 255)));
      else
         send_item(FUNC_SPARE, sym, $urandom, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.func      <= FUNC_LOAD;
      req_ch.symbol    <= 8'd0;
      req_ch.code_bits <= 32'd0;
      req_ch.code_len  <= 8'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty packer, extremes of length, rejects, padding
      send_item(FUNC_FLUSH,  8'd0,   32'd0,          8'd0);
      send_item(FUNC_ENCODE, 8'd5,   32'hFFFF_FFFF,  8'd255);
      send_item(FUNC_LOAD,   8'd255, 32'hA5C3_0F96,  8'd32);
      send_item(FUNC_LOAD,   8'd0,   32'hFFFF_FFFF,  8'd1);
      send_item(FUNC_LOAD,   8'd3,   32'hFFFF_FF5A,  8'd8);
      send_item(FUNC_LOAD,   8'd7,   32'hFFFF_FFFF,  8'd0);
      send_item(FUNC_LOAD,   8'd3,   32'h0000_0000,  8'd33);
      send_item(FUNC_LOAD,   8'd9,   32'h1234_5678,  8'd255);
      send_item(FUNC_ENCODE, 8'd255, 32'd0,          8'd0);
      send_item(FUNC_ENCODE, 8'd0,   32'd0,          8'd0);
      send_item(FUNC_FLUSH,  8'd0,   32'd0,          8'd0);
      send_item(FUNC_ENCODE, 8'd7,   32'd0,          8'd0);
      send_item(FUNC_FLUSH,  8'd0,   32'd0,          8'd0);
      send_item(FUNC_ENCODE, 8'd3,   32'd0,          8'd0);
      send_item(FUNC_FLUSH,  8'd255, 32'hFFFF_FFFF,  8'd255);
      repeat (7) send_item(FUNC_ENCODE, 8'd0, 32'd0, 8'd0);
      send_item(FUNC_ENCODE, 8'd255, 32'd0,          8'd0);
      send_item(FUNC_SPARE,  8'd255, 32'hFFFF_FFFF,  8'd255);
      send_item(FUNC_FLUSH,  8'd0,   32'd0,          8'd0);

      // random: fill a working set of symbols, then mostly encode from it
      foreach (hot[i])
         hot[i] = 8'($urandom_range(0, 255));
      foreach (hot[i])
         send_item(FUNC_LOAD, hot[i], $urandom, 8'($urandom_range(1, MAX_LEN)));
      for (int k = 0; k < 394; k++) begin
         if (k == 180)
            drain_results();
         if (k == 330)
            idle_on = 1'b0;
         random_item();
      end
      send_item(FUNC_FLUSH, 8'd0, 32'd0, 8'd0);

      drain_results();
      repeat (20) @(posedge clock);

      $display("covered %0d loads (%0d rejected), %0d encodes, %0d flushes, %0d unused func",
               sb.loads, sb.rejects, sb.encodes, sb.flushes, sb.spares);
      $display("%0d response items checked, %0d errors", sb.results_seen, sb.errors);
      if (sb.errors == 0 && sb.owed.size() == 0)
         $display("huffman_code_bit_packer_tb: done, clean");
      else
         $display("huffman_code_bit_packer_tb: done, errors");
      $finish;
   end

endmodule
